### rtl/core/vgu_pkg.sv
// Shared types and constants for the vector geometry unit.
package vgu_pkg;

  localparam int NUM_REGS = 8;
  localparam int REG_W    = 64;
  localparam int IDX_W    = 3;
  localparam int NUM_LANE = 4;
  localparam int NUM_TERM = 4;
  localparam int FRAC_W   = 16;
  localparam int OPND_W   = 33;
  localparam int PROD_W   = 2 * OPND_W;
  localparam int PAIR_W   = PROD_W + 1;
  localparam int SUM_W    = PAIR_W + 1;
  localparam int QUOT_W   = SUM_W - FRAC_W;

  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  localparam logic [NUM_REGS-1:0][REG_W-1:0] CFG_RST = {
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  typedef enum logic [1:0] {
    OP_XFORM = 2'd0,
    OP_CROSS = 2'd1,
    OP_DOT   = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
  } opnd_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } en_t;

  function automatic logic signed [OPND_W-1:0] sx33(input logic signed [31:0] v);
    return OPND_W'(v);
  endfunction

  function automatic logic signed [OPND_W-1:0] neg33(input logic signed [31:0] v);
    return -OPND_W'(v);
  endfunction

endpackage

### rtl/core/vgu_lane.sv
// One output lane: four products, pair sums, final sum, shift and saturate.
module vgu_lane import vgu_pkg::*; (
  input  logic               clk,
  input  en_t                en,
  input  opnd_t              opnd [NUM_TERM],
  output logic signed [31:0] res,
  output logic               sat
);

  logic signed [PROD_W-1:0] prod_r [NUM_TERM];
  logic signed [PAIR_W-1:0] pair_r [2];
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [QUOT_W-1:0] quot_nxt;
  logic signed [31:0]       res_nxt;
  logic                     sat_nxt;
  logic signed [31:0]       res_r;
  logic                     sat_r;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int j = 0; j < NUM_TERM; j++) begin
        prod_r[j] <= opnd[j].a * opnd[j].b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      pair_r[0] <= PAIR_W'(prod_r[0]) + PAIR_W'(prod_r[1]);
      pair_r[1] <= PAIR_W'(prod_r[2]) + PAIR_W'(prod_r[3]);
    end
  end

  always_comb begin
    sum_nxt  = SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]);
    quot_nxt = sum_nxt[SUM_W-1:FRAC_W];
    sat_nxt  = (|quot_nxt[QUOT_W-1:31]) && !(&quot_nxt[QUOT_W-1:31]);
    if (sat_nxt) begin
      res_nxt = quot_nxt[QUOT_W-1] ? INT_MIN : INT_MAX;
    end else begin
      res_nxt = quot_nxt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

### rtl/core/vector_geometry_unit.sv
// Vector geometry unit top level: matrix transform, cross and dot product.
// The four-stage multiply-add pipeline sets the latency: stage 1 registers the operands,
// stage 2 the products, stage 3 the pair sums and stage 4 the saturated result and out_valid.
// Throughput: one transaction per cycle while out_stall is low.
// Stages drain independently, so bubbles collapse while the output is stalled.
// Synchronous active-low reset empties the pipeline and loads the identity matrix.
module vector_geometry_unit import vgu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  logic [NUM_REGS-1:0][REG_W-1:0] cfg_r;
  logic  v1_r, v2_r, v3_r, v4_r;
  op_t   op1_r, op2_r, op3_r, op4_r;
  logic  rdy1, rdy2, rdy3, rdy4;
  en_t   lane_en;
  opnd_t opnd_nxt [NUM_LANE][NUM_TERM];
  opnd_t opnd_r   [NUM_LANE][NUM_TERM];
  logic signed [31:0] lane_res [NUM_LANE];
  logic  lane_sat [NUM_LANE];
  logic signed [31:0] mat [NUM_LANE][NUM_TERM];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else if (cfg_valid) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LANE; i++) begin
      for (int j = 0; j < NUM_TERM; j++) begin
        mat[i][j] = cfg_r[i * 2 + j / 2][(j % 2) * 32 +: 32];
      end
    end
  end

  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign lane_en  = '{s2: rdy2, s3: rdy3, s4: rdy4};

  always_comb begin
    for (int i = 0; i < NUM_LANE; i++) begin
      for (int j = 0; j < NUM_TERM; j++) begin
        opnd_nxt[i][j] = '0;
      end
    end
    case (in_data.opcode)
      OP_XFORM: begin
        for (int i = 0; i < NUM_LANE; i++) begin
          opnd_nxt[i][0] = '{a: sx33(in_data.a_x), b: sx33(mat[i][0])};
          opnd_nxt[i][1] = '{a: sx33(in_data.a_y), b: sx33(mat[i][1])};
          opnd_nxt[i][2] = '{a: sx33(in_data.a_z), b: sx33(mat[i][2])};
          opnd_nxt[i][3] = '{a: sx33(in_data.a_w), b: sx33(mat[i][3])};
        end
      end
      OP_CROSS: begin
        opnd_nxt[0][0] = '{a: sx33(in_data.a_y),  b: sx33(in_data.b_z)};
        opnd_nxt[0][1] = '{a: neg33(in_data.a_z), b: sx33(in_data.b_y)};
        opnd_nxt[1][0] = '{a: sx33(in_data.a_z),  b: sx33(in_data.b_x)};
        opnd_nxt[1][1] = '{a: neg33(in_data.a_x), b: sx33(in_data.b_z)};
        opnd_nxt[2][0] = '{a: sx33(in_data.a_x),  b: sx33(in_data.b_y)};
        opnd_nxt[2][1] = '{a: neg33(in_data.a_y), b: sx33(in_data.b_x)};
      end
      OP_DOT: begin
        opnd_nxt[0][0] = '{a: sx33(in_data.a_x), b: sx33(in_data.b_x)};
        opnd_nxt[0][1] = '{a: sx33(in_data.a_y), b: sx33(in_data.b_y)};
        opnd_nxt[0][2] = '{a: sx33(in_data.a_z), b: sx33(in_data.b_z)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r  <= in_data.opcode;
      opnd_r <= opnd_nxt;
    end
    if (rdy2) op2_r <= op1_r;
    if (rdy3) op3_r <= op2_r;
    if (rdy4) op4_r <= op3_r;
  end

  for (genvar g = 0; g < NUM_LANE; g++) begin : g_lane
    vgu_lane u_lane (
      .clk  (clk),
      .en   (lane_en),
      .opnd (opnd_r[g]),
      .res  (lane_res[g]),
      .sat  (lane_sat[g])
    );
  end

  assign out_valid          = v4_r;
  assign out_data.r_x       = lane_res[0];
  assign out_data.r_y       = lane_res[1];
  assign out_data.r_z       = lane_res[2];
  assign out_data.r_w       = (op4_r == OP_CROSS) ? Q_ONE : lane_res[3];
  assign out_data.saturated = lane_sat[0] | lane_sat[1] | lane_sat[2] | lane_sat[3];

endmodule
